// File: hdl/three_stream_timestamp_matcher_top_macros.svh
// Assertion macros used by the checker in tstm_checker.sv.
`ifndef THREE_STREAM_TIMESTAMP_MATCHER_TOP_MACROS_SVH
`define THREE_STREAM_TIMESTAMP_MATCHER_TOP_MACROS_SVH

// Same-cycle implication, off while reset is low.
`define TSTM_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is low.
`define TSTM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/tstm_pkg.sv
`default_nettype none
package tstm_pkg;

  localparam int NUM_CAMS = 3;
  localparam int TS_W     = 48;
  localparam int TAG_W    = 16;
  localparam int SPR_W    = 24;
  localparam int NUM_W    = 6;
  localparam int WIN_W    = 16;

  localparam int IN_DATA_W  = 64;
  localparam int IN_USER_W  = 5;
  localparam int OUT_DATA_W = 192;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // output tdata field offsets
  localparam int TRIP_FIELDS_W = 120;  // tags, sync time, spread
  localparam int BEST_LSB      = 138;
  localparam int WORST_LSB     = 162;

  // deviation limits: up to 65536 ms in us
  localparam int DEV_W = 27;
  localparam int REM_W = 26;
  localparam logic [9:0] US_PER_MS = 10'd1000;

  // floor(x/1000) = (x * ceil(2^36/1000)) >> 36, exact for x < 2^26
  localparam int RECIP_W       = 27;
  localparam int PROD_W        = REM_W + RECIP_W;
  localparam int DIV1000_SHIFT = 36;
  localparam logic [RECIP_W-1:0] DIV1000_RECIP = 27'd68719477;

  localparam logic [1:0] OP_LOAD     = 2'd0;
  localparam logic [1:0] OP_RUN      = 2'd1;
  localparam logic [1:0] OP_CLEAR    = 2'd2;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  localparam logic [1:0] CAM_NONE = 2'd3;

  localparam logic KIND_TRIPLET = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [1:0] REG_WINDOW  = 2'd0;
  localparam logic [1:0] REG_MAXSPR  = 2'd1;
  localparam logic [1:0] REG_PERFECT = 2'd2;
  localparam logic [1:0] REG_GOOD    = 2'd3;

  localparam logic [WIN_W-1:0] WINDOW_RST  = 16'd33;
  localparam logic [SPR_W-1:0] MAXSPR_RST  = 24'd33000;
  localparam logic [SPR_W-1:0] PERFECT_RST = 24'd5000;
  localparam logic [SPR_W-1:0] GOOD_RST    = 24'd16700;

endpackage
`default_nettype wire

// File: hdl/three_stream_timestamp_matcher_top.sv
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: ts, tag; tuser: op, cam, valid
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: triplet/summary; tuser: kind; tlast
// cfg       in   cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// Load and clear items are handled in idle. A run item walks the frame memory, one pass
// over one camera at a time: three passes find the start time, then each camera-1 frame
// takes a camera-1 pass and up to two neighbor passes, each followed by a divide (only when
// a next frame matches) and a decide step, then evaluate and emit; a last
// camera-1 pass and the summary end the run. Input is taken only in idle; a pending
// result does not block it. Results wait in the output register while m_axis_tready is low.
`default_nettype none
module three_stream_timestamp_matcher_top #(
  parameter int FRAME_DEPTH = 32
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [47:0] timestamp_us, [63:48] frame_tag
  input  wire  [tstm_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // [1:0] operation, [3:2] camera, [4] frame_valid
  input  wire  [tstm_pkg::IN_USER_W-1:0]       s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  // [15:0] first_tag, [31:16] second_tag, [47:32] third_tag, [95:48] sync_time_us,
  // [119:96] spread_us, [125:120] triplet_number, [131:126] perfect_count,
  // [137:132] good_count, [161:138] best_spread_us, [185:162] worst_spread_us
  output logic [tstm_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // [0] kind
  output logic                                 m_axis_tuser,
  output logic                                 m_axis_tlast,
  input  wire                                  cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire  [tstm_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire  [tstm_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import tstm_pkg::*;

  localparam int CW        = $clog2(FRAME_DEPTH + 1);
  localparam int MEM_DEPTH = NUM_CAMS * FRAME_DEPTH;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int REC_W     = TS_W + TAG_W + 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MIN_SCAN, ST_C1_SCAN, ST_NB_SCAN, ST_DIV, ST_DECIDE,
    ST_EVAL, ST_EMIT, ST_SUMMARY
  } state_e;

  state_e state_q;

  logic [REC_W-1:0] mem [MEM_DEPTH];
  logic [REC_W-1:0] rdata_q;

  logic [CW-1:0]    cnt_q [NUM_CAMS];
  logic [WIN_W-1:0] win_q;
  logic [SPR_W-1:0] maxspr_q, perf_thr_q, good_thr_q;

  logic [1:0]    scan_cam_q;
  logic [CW-1:0] j_q, rd_j_q;
  logic          rd_vld_q;

  logic [TS_W-1:0]  lo_q, start_q;
  logic             b_has_q, cur_has_q, n_has_q, p_has_q;
  logic [TS_W-1:0]  b_t_q, cur_t_q, n_t_q, p_t_q, s2_t_q, s3_t_q;
  logic [TAG_W-1:0] b_tag_q, cur_tag_q, n_tag_q, p_tag_q, s2_tag_q, s3_tag_q;
  logic [CW-1:0]    b_j_q, cur_j_q;

  logic [REM_W-1:0] rem_q;
  logic [15:0]      quo_q;
  logic             matched_q;

  logic [SPR_W-1:0] spread_q, best_q, worst_q;
  logic [NUM_W-1:0] tot_q, perf_cnt_q, good_cnt_q;

  logic                  m_tvalid_q;
  logic [OUT_DATA_W-1:0] m_tdata_q;
  logic                  m_tuser_q;

  // input decode
  logic [TS_W-1:0]  in_ts;
  logic [TAG_W-1:0] in_tag;
  logic [1:0]       in_op, in_cam;
  logic             in_fv, acc;
  logic [CW-1:0]    in_cnt;
  logic             wr_en;
  logic [AW-1:0]    wr_addr, rd_addr;

  // scan and datapath
  logic             scanning, issue, scan_done;
  logic [CW-1:0]    scan_cnt;
  logic [TS_W-1:0]  rd_t;
  logic [TAG_W-1:0] rd_tag;
  logic             rd_v, rd_kept;
  logic [DEV_W-1:0] win_lim, lim_us;
  logic [TS_W-1:0]  dn, dp;
  logic             match_n, prev_win;
  logic [PROD_W-1:0] quo_prod;
  logic [TS_W-1:0]  lo3, hi3, spread_full;
  logic             out_free, emit_now;

  always_comb begin
    in_ts  = s_axis_tdata[TS_W-1:0];
    in_tag = s_axis_tdata[TS_W +: TAG_W];
    in_op  = s_axis_tuser[1:0];
    in_cam = s_axis_tuser[3:2];
    in_fv  = s_axis_tuser[4];
    acc    = s_axis_tvalid && s_axis_tready;
    case (in_cam)
      2'd0:    in_cnt = cnt_q[0];
      2'd1:    in_cnt = cnt_q[1];
      2'd2:    in_cnt = cnt_q[2];
      default: in_cnt = '0;
    endcase
    wr_en   = acc && (in_op == OP_LOAD) && (in_cam != CAM_NONE) &&
              (in_cnt < CW'(FRAME_DEPTH));
    wr_addr = AW'(in_cam) * AW'(FRAME_DEPTH) + AW'(in_cnt);

    scanning  = (state_q == ST_MIN_SCAN) || (state_q == ST_C1_SCAN) ||
                (state_q == ST_NB_SCAN);
    case (scan_cam_q)
      2'd0:    scan_cnt = cnt_q[0];
      2'd1:    scan_cnt = cnt_q[1];
      2'd2:    scan_cnt = cnt_q[2];
      default: scan_cnt = '0;
    endcase
    issue     = scanning && (j_q < scan_cnt);
    scan_done = scanning && !issue && !rd_vld_q;
    rd_addr   = AW'(scan_cam_q) * AW'(FRAME_DEPTH) + AW'(j_q);

    rd_t    = rdata_q[TS_W-1:0];
    rd_tag  = rdata_q[TS_W +: TAG_W];
    rd_v    = rdata_q[REC_W-1];
    rd_kept = rd_v && (rd_t >= start_q);

    // floor(d/1000) <= W  <=>  d < 1000*(W+1)
    win_lim  = DEV_W'({1'b0, win_q} + 17'd1) * DEV_W'(US_PER_MS);
    dn       = n_t_q - cur_t_q;
    match_n  = n_has_q && (dn < TS_W'(win_lim));
    lim_us   = matched_q ? DEV_W'(quo_q) * DEV_W'(US_PER_MS)
                         : DEV_W'(win_q) * DEV_W'(US_PER_MS);
    dp       = cur_t_q - p_t_q;
    prev_win = p_has_q && (dp < TS_W'(lim_us));
    quo_prod = PROD_W'(rem_q) * PROD_W'(DIV1000_RECIP);

    lo3 = cur_t_q;
    hi3 = cur_t_q;
    if (s2_t_q < lo3) lo3 = s2_t_q;
    if (s2_t_q > hi3) hi3 = s2_t_q;
    if (s3_t_q < lo3) lo3 = s3_t_q;
    if (s3_t_q > hi3) hi3 = s3_t_q;
    spread_full = hi3 - lo3;

    out_free = !m_tvalid_q || m_axis_tready;
    emit_now = ((state_q == ST_EMIT) || (state_q == ST_SUMMARY)) && out_free;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= {in_fv, in_tag, in_ts};
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      for (int c = 0; c < NUM_CAMS; c++) cnt_q[c] <= '0;
      win_q      <= WINDOW_RST;
      maxspr_q   <= MAXSPR_RST;
      perf_thr_q <= PERFECT_RST;
      good_thr_q <= GOOD_RST;
      scan_cam_q <= '0;
      j_q        <= '0;
      rd_j_q     <= '0;
      rd_vld_q   <= 1'b0;
      lo_q       <= '0;
      start_q    <= '0;
      b_has_q    <= 1'b0;
      cur_has_q  <= 1'b0;
      n_has_q    <= 1'b0;
      p_has_q    <= 1'b0;
      b_t_q      <= '0;
      cur_t_q    <= '0;
      n_t_q      <= '0;
      p_t_q      <= '0;
      s2_t_q     <= '0;
      s3_t_q     <= '0;
      b_tag_q    <= '0;
      cur_tag_q  <= '0;
      n_tag_q    <= '0;
      p_tag_q    <= '0;
      s2_tag_q   <= '0;
      s3_tag_q   <= '0;
      b_j_q      <= '0;
      cur_j_q    <= '0;
      rem_q      <= '0;
      quo_q      <= '0;
      matched_q  <= 1'b0;
      spread_q   <= '0;
      best_q     <= '0;
      worst_q    <= '0;
      tot_q      <= '0;
      perf_cnt_q <= '0;
      good_cnt_q <= '0;
      m_tvalid_q <= 1'b0;
      m_tdata_q  <= '0;
      m_tuser_q  <= KIND_TRIPLET;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_WINDOW:  win_q      <= cfg_data_i[WIN_W-1:0];
          REG_MAXSPR:  maxspr_q   <= cfg_data_i;
          REG_PERFECT: perf_thr_q <= cfg_data_i;
          REG_GOOD:    good_thr_q <= cfg_data_i;
          default:     ;
        endcase
      end

      if (m_tvalid_q && m_axis_tready && !emit_now) m_tvalid_q <= 1'b0;

      if (scanning) begin
        if (issue) j_q <= j_q + 1'b1;
        rd_vld_q <= issue;
        rd_j_q   <= j_q;
      end

      case (state_q)
        ST_IDLE: begin
          if (acc) begin
            case (in_op)
              OP_LOAD: begin
                if (wr_en) begin
                  case (in_cam)
                    2'd0:    cnt_q[0] <= cnt_q[0] + 1'b1;
                    2'd1:    cnt_q[1] <= cnt_q[1] + 1'b1;
                    2'd2:    cnt_q[2] <= cnt_q[2] + 1'b1;
                    default: ;
                  endcase
                end
              end
              OP_CLEAR: begin
                for (int c = 0; c < NUM_CAMS; c++) cnt_q[c] <= '0;
              end
              OP_RUN: begin
                tot_q      <= '0;
                perf_cnt_q <= '0;
                good_cnt_q <= '0;
                best_q     <= '0;
                worst_q    <= '0;
                start_q    <= '0;
                scan_cam_q <= 2'd0;
                j_q        <= '0;
                rd_vld_q   <= 1'b0;
                if ((cnt_q[0] == '0) || (cnt_q[1] == '0) || (cnt_q[2] == '0)) begin
                  state_q <= ST_SUMMARY;
                end else begin
                  state_q <= ST_MIN_SCAN;
                end
              end
              default: ;
            endcase
          end
        end

        ST_MIN_SCAN: begin
          // earliest frame per camera, invalid ones included
          if (rd_vld_q && ((rd_j_q == '0) || (rd_t < lo_q))) lo_q <= rd_t;
          if (scan_done) begin
            if (lo_q > start_q) start_q <= lo_q;
            j_q <= '0;
            if (scan_cam_q == 2'd2) begin
              scan_cam_q <= 2'd0;
              b_has_q    <= 1'b0;
              cur_has_q  <= 1'b0;
              state_q    <= ST_C1_SCAN;
            end else begin
              scan_cam_q <= scan_cam_q + 2'd1;
            end
          end
        end

        ST_C1_SCAN: begin
          // smallest (time, index) after the current camera-1 frame
          if (rd_vld_q && rd_kept &&
              (!cur_has_q || (rd_t > cur_t_q) || ((rd_t == cur_t_q) && (rd_j_q > cur_j_q))) &&
              (!b_has_q || (rd_t < b_t_q))) begin
            b_has_q <= 1'b1;
            b_t_q   <= rd_t;
            b_tag_q <= rd_tag;
            b_j_q   <= rd_j_q;
          end
          if (scan_done) begin
            if (!b_has_q) begin
              state_q <= ST_SUMMARY;
            end else begin
              cur_has_q  <= 1'b1;
              cur_t_q    <= b_t_q;
              cur_tag_q  <= b_tag_q;
              cur_j_q    <= b_j_q;
              scan_cam_q <= 2'd1;
              j_q        <= '0;
              n_has_q    <= 1'b0;
              p_has_q    <= 1'b0;
              state_q    <= ST_NB_SCAN;
            end
          end
        end

        ST_NB_SCAN: begin
          // first frame at or after t1, and the last one before it
          if (rd_vld_q && rd_kept) begin
            if (rd_t >= cur_t_q) begin
              if (!n_has_q || (rd_t < n_t_q)) begin
                n_has_q <= 1'b1;
                n_t_q   <= rd_t;
                n_tag_q <= rd_tag;
              end
            end else if (!p_has_q || (rd_t >= p_t_q)) begin
              p_has_q <= 1'b1;
              p_t_q   <= rd_t;
              p_tag_q <= rd_tag;
            end
          end
          if (scan_done) begin
            matched_q <= match_n;
            if (match_n) begin
              rem_q   <= dn[REM_W-1:0];
              state_q <= ST_DIV;
            end else begin
              state_q <= ST_DECIDE;
            end
          end
        end

        ST_DIV: begin
          // divide by 1000 through reciprocal multiplication
          quo_q   <= quo_prod[DIV1000_SHIFT +: 16];
          state_q <= ST_DECIDE;
        end

        ST_DECIDE: begin
          j_q <= '0;
          if (!matched_q && !prev_win) begin
            scan_cam_q <= 2'd0;
            b_has_q    <= 1'b0;
            state_q    <= ST_C1_SCAN;
          end else if (scan_cam_q == 2'd1) begin
            s2_t_q     <= prev_win ? p_t_q : n_t_q;
            s2_tag_q   <= prev_win ? p_tag_q : n_tag_q;
            scan_cam_q <= 2'd2;
            n_has_q    <= 1'b0;
            p_has_q    <= 1'b0;
            state_q    <= ST_NB_SCAN;
          end else begin
            s3_t_q   <= prev_win ? p_t_q : n_t_q;
            s3_tag_q <= prev_win ? p_tag_q : n_tag_q;
            state_q  <= ST_EVAL;
          end
        end

        ST_EVAL: begin
          if (spread_full > TS_W'(maxspr_q)) begin
            scan_cam_q <= 2'd0;
            j_q        <= '0;
            b_has_q    <= 1'b0;
            state_q    <= ST_C1_SCAN;
          end else begin
            spread_q <= spread_full[SPR_W-1:0];
            state_q  <= ST_EMIT;
          end
        end

        ST_EMIT: begin
          if (out_free) begin
            m_tvalid_q <= 1'b1;
            m_tuser_q  <= KIND_TRIPLET;
            m_tdata_q  <= {{(OUT_DATA_W - TRIP_FIELDS_W - NUM_W){1'b0}}, tot_q,
                           spread_q, cur_t_q, s3_tag_q, s2_tag_q, cur_tag_q};
            if (spread_q < perf_thr_q) perf_cnt_q <= perf_cnt_q + 1'b1;
            if (spread_q < good_thr_q) good_cnt_q <= good_cnt_q + 1'b1;
            if ((tot_q == '0) || (spread_q < best_q)) best_q <= spread_q;
            if ((tot_q == '0) || (spread_q > worst_q)) worst_q <= spread_q;
            tot_q      <= tot_q + 1'b1;
            scan_cam_q <= 2'd0;
            j_q        <= '0;
            b_has_q    <= 1'b0;
            state_q    <= ST_C1_SCAN;
          end
        end

        ST_SUMMARY: begin
          if (out_free) begin
            m_tvalid_q <= 1'b1;
            m_tuser_q  <= KIND_SUMMARY;
            m_tdata_q  <= {{(OUT_DATA_W - WORST_LSB - SPR_W){1'b0}}, worst_q, best_q,
                           good_cnt_q, perf_cnt_q, tot_q, {TRIP_FIELDS_W{1'b0}}};
            state_q    <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tuser  = m_tuser_q;
  assign m_axis_tlast  = (m_tuser_q == KIND_SUMMARY);

endmodule
`default_nettype wire

// File: hdl/tstm_checker.sv
`default_nettype none
`include "three_stream_timestamp_matcher_top_macros.svh"
module tstm_checker (
  input wire                              clk_i,
  input wire                              rst_ni,
  input wire                              m_axis_tvalid,
  input wire                              m_axis_tready,
  input wire [tstm_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input wire                              m_axis_tuser,
  input wire                              m_axis_tlast
);
  import tstm_pkg::*;

  `TSTM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled item changed")
  `TSTM_ASSERT_NOW(a_last_is_summary, clk_i, rst_ni, m_axis_tvalid, m_axis_tlast == (m_axis_tuser == KIND_SUMMARY), "tlast does not match kind")
  `TSTM_ASSERT_NOW(a_summary_clean, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser == KIND_SUMMARY), m_axis_tdata[TRIP_FIELDS_W-1:0] == '0, "summary carries triplet fields")
  `TSTM_ASSERT_NOW(a_best_le_worst, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser == KIND_SUMMARY), m_axis_tdata[BEST_LSB +: SPR_W] <= m_axis_tdata[WORST_LSB +: SPR_W], "best spread above worst")

endmodule

bind three_stream_timestamp_matcher_top tstm_checker u_tstm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import tstm_pkg::*;

  localparam int DEPTH = 32;
  localparam logic [47:0] TS_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct {
    logic [OUT_DATA_W-1:0] data;
    logic                  kind;
    logic                  last;
  } result_t;

  typedef struct {
    logic [1:0]  op;
    logic [1:0]  cam;
    logic [47:0] ts;
    logic        vld;
    logic [15:0] tag;
    logic        empty_summary;  // expected result is the all-zero summary
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [IN_USER_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  always #6 clk_i = ~clk_i;

  three_stream_timestamp_matcher_top #(.FRAME_DEPTH(DEPTH)) i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // shadow copy of the frame stores and registers
  logic [47:0] frame_ts [NUM_CAMS*DEPTH];
  logic [15:0] frame_tag [NUM_CAMS*DEPTH];
  logic        frame_ok [NUM_CAMS*DEPTH];
  int unsigned frame_cnt [NUM_CAMS];
  logic [15:0] win_ms = WINDOW_RST;
  logic [23:0] max_spr = MAXSPR_RST;
  logic [23:0] perf_thr = PERFECT_RST;
  logic [23:0] good_thr = GOOD_RST;

  result_t pending_results[$];
  int errors = 0;
  int items_sent = 0;
  int runs_sent = 0;
  int triplets_seen = 0;
  int summaries_seen = 0;

  function automatic void add_expected(result_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic result_t make_summary(int unsigned total, int unsigned perf,
                                           int unsigned good, logic [63:0] best,
                                           logic [63:0] worst);
    result_t r;
    r.data = '0;
    r.data[125:120] = total[5:0];
    r.data[131:126] = perf[5:0];
    r.data[137:132] = good[5:0];
    r.data[161:138] = best[23:0];
    r.data[185:162] = worst[23:0];
    r.kind = KIND_SUMMARY;
    r.last = 1'b1;
    return r;
  endfunction

  // kept frames of one camera, ascending time, ties in load order
  function automatic int unsigned collect_kept(int unsigned cam, logic [63:0] start,
                                               ref int unsigned lst[DEPTH]);
    int unsigned n;
    int unsigned slot;
    int unsigned p;
    n = 0;
    for (int unsigned j = 0; j < frame_cnt[cam]; j++) begin
      slot = cam * DEPTH + j;
      if (frame_ok[slot] && frame_ts[slot] >= start) begin
        p = n;
        while (p > 0 && frame_ts[lst[p-1]] > frame_ts[slot]) begin
          lst[p] = lst[p-1];
          p--;
        end
        lst[p] = slot;
        n++;
      end
    end
    return n;
  endfunction

  function automatic bit nearest_frame(ref int unsigned lst[DEPTH], input int unsigned n,
                                       input logic [63:0] target, output int unsigned sel);
    int unsigned p;
    logic [63:0] lim;
    logic [63:0] dev;
    bit hit;
    p = 0;
    hit = 0;
    sel = 0;
    lim = win_ms;
    while (p < n && frame_ts[lst[p]] < target) p++;
    if (p < n) begin
      dev = (frame_ts[lst[p]] - target) / 1000;
      if (dev <= win_ms) begin
        hit = 1;
        sel = lst[p];
        lim = dev;
      end
    end
    if (p > 0) begin
      dev = (target - frame_ts[lst[p-1]]) / 1000;
      if (dev < lim) begin
        hit = 1;
        sel = lst[p-1];
      end
    end
    return hit;
  endfunction

  function automatic void predict_item(logic [1:0] op, logic [1:0] cam, logic [47:0] ts,
                                       logic vld, logic [15:0] tag, bit keep);
    int unsigned kept0[DEPTH];
    int unsigned kept1[DEPTH];
    int unsigned kept2[DEPTH];
    int unsigned n0, n1, n2, s2, s3, slot;
    int unsigned total, perf, good;
    logic [63:0] start, lo, hi, spread, best, worst, t1;
    result_t r;
    total = 0; perf = 0; good = 0; best = 0; worst = 0; start = 0;
    if (op == OP_LOAD) begin
      if (cam != CAM_NONE && frame_cnt[cam] < DEPTH) begin
        slot = cam * DEPTH + frame_cnt[cam];
        frame_ts[slot] = ts;
        frame_ok[slot] = vld;
        frame_tag[slot] = tag;
        frame_cnt[cam]++;
      end
      return;
    end
    if (op == OP_CLEAR) begin
      foreach (frame_cnt[c]) frame_cnt[c] = 0;
      return;
    end
    if (op != OP_RUN) return;
    if (frame_cnt[0] != 0 && frame_cnt[1] != 0 && frame_cnt[2] != 0) begin
      for (int unsigned c = 0; c < NUM_CAMS; c++) begin
        lo = frame_ts[c*DEPTH];
        for (int unsigned i = 1; i < frame_cnt[c]; i++)
          if (frame_ts[c*DEPTH+i] < lo) lo = frame_ts[c*DEPTH+i];
        if (lo > start) start = lo;
      end
      n0 = collect_kept(0, start, kept0);
      n1 = collect_kept(1, start, kept1);
      n2 = collect_kept(2, start, kept2);
      for (int unsigned i = 0; i < n0; i++) begin
        t1 = frame_ts[kept0[i]];
        if (!nearest_frame(kept1, n1, t1, s2)) continue;
        if (!nearest_frame(kept2, n2, t1, s3)) continue;
        lo = t1; hi = t1;
        if (frame_ts[s2] < lo) lo = frame_ts[s2];
        if (frame_ts[s2] > hi) hi = frame_ts[s2];
        if (frame_ts[s3] < lo) lo = frame_ts[s3];
        if (frame_ts[s3] > hi) hi = frame_ts[s3];
        spread = hi - lo;
        if (spread > max_spr) continue;
        r.data = '0;
        r.data[15:0]    = frame_tag[kept0[i]];
        r.data[31:16]   = frame_tag[s2];
        r.data[47:32]   = frame_tag[s3];
        r.data[95:48]   = t1[47:0];
        r.data[119:96]  = spread[23:0];
        r.data[125:120] = total[5:0];
        r.kind = KIND_TRIPLET;
        r.last = 1'b0;
        if (keep) add_expected(r);
        if (spread < perf_thr) perf++;
        if (spread < good_thr) good++;
        if (total == 0 || spread < best) best = spread;
        if (total == 0 || spread > worst) worst = spread;
        total++;
      end
    end
    if (keep) add_expected(make_summary(total, perf, good, best, worst));
  endfunction

  // one input item; tvalid stays high across back-to-back items
  task automatic send_item(logic [1:0] op, logic [1:0] cam, logic [47:0] ts, logic vld,
                           logic [15:0] tag, bit literal_summary);
    int unsigned gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {tag, ts};
    s_axis_tuser  <= {vld, cam, op};
    do @(posedge clk_i); while (!s_axis_tready);
    if (literal_summary) begin
      predict_item(op, cam, ts, vld, tag, 0);
      add_expected(make_summary(0, 0, 0, 0, 0));
    end else begin
      predict_item(op, cam, ts, vld, tag, 1);
    end
    items_sent++;
    if (op == OP_RUN) runs_sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_WINDOW:  win_ms   = val[15:0];
      REG_MAXSPR:  max_spr  = val;
      REG_PERFECT: perf_thr = val;
      default:     good_thr = val;
    endcase
    @(posedge clk_i);
  endtask

  // receiver with random stalls
  initial begin
    int unsigned stall;
    result_t want;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, 3);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      if (m_axis_tuser == KIND_SUMMARY) summaries_seen++;
      else triplets_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected item kind=%0d data=%h", $time, m_axis_tuser, m_axis_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata !== want.data) begin
          $display("%0t: tdata mismatch expected %h actual %h", $time, want.data,
                   m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser !== want.kind) begin
          $display("%0t: kind mismatch expected %0d actual %0d", $time, want.kind,
                   m_axis_tuser);
          errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $display("%0t: tlast mismatch expected %0d actual %0d", $time, want.last,
                   m_axis_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    #50ms;
    $display("three_stream_timestamp_matcher_top test failed");
    $finish;
  end

  row_t directed[] = '{
    '{OP_RUN,   2'd0, 48'd0,      1'b0, 16'h0000, 1'b1},
    '{OP_RESERVED, 2'd1, TS_MAX,  1'b1, 16'hFFFF, 1'b0},
    '{OP_LOAD,  CAM_NONE, 48'd5,  1'b1, 16'h1111, 1'b0},
    '{OP_LOAD,  2'd0, 48'd0,      1'b1, 16'h0000, 1'b0},
    '{OP_LOAD,  2'd1, 48'd1000,   1'b1, 16'hFFFF, 1'b0},
    '{OP_RUN,   2'd0, 48'd0,      1'b0, 16'h0000, 1'b1},
    '{OP_LOAD,  2'd2, 48'd2000,   1'b0, 16'h00A5, 1'b0},
    '{OP_RUN,   2'd0, 48'd0,      1'b0, 16'h0000, 1'b0},
    '{OP_LOAD,  2'd2, 48'd3000,   1'b1, 16'h1234, 1'b0},
    '{OP_RUN,   2'd0, 48'd0,      1'b0, 16'h0000, 1'b0},
    '{OP_LOAD,  2'd0, 48'd33000,  1'b1, 16'h0101, 1'b0},
    '{OP_LOAD,  2'd1, 48'd33000,  1'b1, 16'h0202, 1'b0},
    '{OP_LOAD,  2'd1, 48'd33000,  1'b1, 16'h0203, 1'b0},
    '{OP_LOAD,  2'd2, 48'd66999,  1'b1, 16'h0303, 1'b0},
    '{OP_RUN,   2'd0, 48'd0,      1'b0, 16'h0000, 1'b0},
    '{OP_CLEAR, 2'd0, 48'd0,      1'b0, 16'h0000, 1'b0},
    '{OP_RUN,   2'd0, 48'd0,      1'b0, 16'h0000, 1'b1},
    '{OP_LOAD,  2'd0, TS_MAX,     1'b1, 16'hAAAA, 1'b0},
    '{OP_LOAD,  2'd1, TS_MAX,     1'b1, 16'h5555, 1'b0},
    '{OP_LOAD,  2'd2, TS_MAX - 48'd4999, 1'b1, 16'hC3C3, 1'b0},
    '{OP_RUN,   2'd0, 48'd0,      1'b0, 16'h0000, 1'b0},
    '{OP_CLEAR, 2'd3, 48'd0,      1'b0, 16'h0000, 1'b0}
  };

  initial begin
    logic [47:0] base, ts;
    int unsigned nfr, period, jit, sel;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i])
      send_item(directed[i].op, directed[i].cam, directed[i].ts, directed[i].vld,
                directed[i].tag, directed[i].empty_summary);

    while (items_sent < 265) begin
      // register phase between frame sets
      if ($urandom_range(0, 3) == 0) begin
        wait_idle();
        sel = $urandom_range(0, 4);
        case (sel)
          0: begin
            write_reg(REG_WINDOW, 24'd0);
            write_reg(REG_MAXSPR, 24'hFFFFFF);
          end
          1: begin
            write_reg(REG_WINDOW, 24'd65535);
            write_reg(REG_MAXSPR, 24'd0);
          end
          2: begin
            write_reg(REG_PERFECT, 24'd0);
            write_reg(REG_GOOD, 24'hFFFFFF);
          end
          3: begin
            write_reg(REG_PERFECT, 24'hFFFFFF);
            write_reg(REG_GOOD, 24'd0);
          end
          default: begin
            write_reg(REG_WINDOW, 24'($urandom_range(5, 60)));
            write_reg(REG_MAXSPR, 24'($urandom_range(5000, 60000)));
            write_reg(REG_PERFECT, 24'($urandom_range(1000, 10000)));
            write_reg(REG_GOOD, 24'($urandom_range(10000, 30000)));
          end
        endcase
      end
      send_item(OP_CLEAR, 2'($urandom), 48'({$urandom, $urandom}), 1'($urandom),
                16'($urandom), 0);
      base = 48'({$urandom, $urandom});
      if (base > TS_MAX - 48'd4000000) base = base - 48'd4000000;
      period = $urandom_range(0, 1) ? 33333 : $urandom_range(1000, 50000);
      jit = $urandom_range(0, 1) ? 2000 : 40000;
      for (int c = 0; c < NUM_CAMS; c++) begin
        nfr = $urandom_range(1, 5);
        if ($urandom_range(0, 11) == 0) nfr = 0;
        if ($urandom_range(0, 15) == 0) nfr = $urandom_range(30, 34);
        for (int k = 0; k < nfr; k++) begin
          if ($urandom_range(0, 3) == 0)
            ts = base + 48'($urandom_range(0, nfr * period));
          else
            ts = base + 48'(k * period) + 48'($urandom_range(0, jit));
          send_item(OP_LOAD, 2'(c), ts, $urandom_range(0, 5) != 0, 16'($urandom), 0);
          // stray items: unknown operation or camera
          if ($urandom_range(0, 19) == 0)
            send_item($urandom_range(0, 1) ? OP_RESERVED : OP_LOAD, CAM_NONE,
                      48'({$urandom, $urandom}), 1'($urandom), 16'($urandom), 0);
        end
      end
      send_item(OP_RUN, 2'($urandom), 48'({$urandom, $urandom}), 1'($urandom),
                16'($urandom), 0);
    end

    wait_idle();
    repeat (50) @(posedge clk_i);
    $display("Sent %0d items with %0d runs; checked %0d triplets and %0d summaries.",
             items_sent, runs_sent, triplets_seen, summaries_seen);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("three_stream_timestamp_matcher_top test passed");
    end else begin
      $display("three_stream_timestamp_matcher_top test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/tstm_pkg.sv
hdl/three_stream_timestamp_matcher_top.sv
hdl/tstm_checker.sv
bench/tb_top.sv
